// ----- hw/rtl/mlfr_pkg.sv -----
// Package with the shared types and constants of the frame receiver.
`timescale 1ns / 1ps

package mlfr_pkg;

    // Header bytes ahead of the payload: magic, type, sequence, length
    localparam int unsigned HDR_LEN = 4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY = 2'd3;

    // Configuration reset values
    localparam logic [7:0] MAGIC_RST   = 8'd165;
    localparam logic [7:0] TYPE_A_RST  = 8'd1;
    localparam logic [7:0] TYPE_B_RST  = 8'd2;
    localparam logic [5:0] MAX_PAY_RST = 6'd60;

    // Operation codes of an input item
    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef enum logic [2:0] {
        PS_MAGIC,
        PS_TYPE,
        PS_SEQ,
        PS_LEN,
        PS_PAYLOAD
    } t_parse_st;

    typedef enum logic {
        TS_IDLE,
        TS_READ
    } t_top_st;

    typedef struct packed {
        logic [7:0] magic;
        logic [7:0] type_a;
        logic [7:0] type_b;
        logic [5:0] max_pay;
    } t_cfg;

    // Parser status after the current step
    typedef struct packed {
        logic        ready;
        logic [31:0] rcv_bytes;
        logic [31:0] done_frames;
    } t_parse_stat;

endpackage

// ----- hw/rtl/mlfr_buf.sv -----
// Single-frame byte buffer: one write port, one registered read port.
`timescale 1ns / 1ps

module mlfr_buf #(
    parameter int unsigned BUF_SIZE = 64
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(BUF_SIZE)-1:0] i_wr_addr,
    input  logic [7:0]                  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(BUF_SIZE)-1:0] i_rd_addr,
    output logic [7:0]                  o_rd_data
);

    logic [7:0] r_mem [BUF_SIZE];
    logic [7:0] r_rd_data;

    // Store a frame byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read and hold until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/mlfr_parse.sv -----
// Header parser, fill tracking and byte/frame counters.
`timescale 1ns / 1ps

module mlfr_parse #(
    parameter int unsigned BUF_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mlfr_pkg::t_cfg                i_cfg,
    input  logic                          i_rx,
    input  logic [7:0]                    i_byte,
    input  logic                          i_clear,
    output logic                          o_wr_en,
    output logic [$clog2(BUF_SIZE)-1:0]   o_wr_addr,
    output logic [7:0]                    o_wr_data,
    output logic                          o_ready,
    output logic [$clog2(BUF_SIZE+1)-1:0] o_fill,
    output mlfr_pkg::t_parse_stat         o_stat
);

    localparam int unsigned FW = $clog2(BUF_SIZE + 1);
    localparam int unsigned AW = $clog2(BUF_SIZE);

    mlfr_pkg::t_parse_st r_st, n_st;
    logic [FW-1:0]       r_fill, n_fill;
    logic [FW-1:0]       r_exp, n_exp;
    logic                r_ready, n_ready;
    logic [31:0]         r_bytes, n_bytes;
    logic [31:0]         r_frames, n_frames;

    logic                restart;
    logic                type_ok;
    logic                len_bad;
    logic                room;
    logic                pay_done;
    logic                step;
    logic [FW-1:0]       fill_inc;
    logic [FW-1:0]       exp_len;
    logic [8:0]          len_total;

    // Decode the byte against the header rules
    always_comb begin
        step      = i_rx && !r_ready;
        restart   = (i_byte == i_cfg.magic) && (r_st != mlfr_pkg::PS_PAYLOAD);
        type_ok   = (i_byte == i_cfg.type_a) || (i_byte == i_cfg.type_b);
        len_total = {1'b0, i_byte} + 9'(mlfr_pkg::HDR_LEN);
        len_bad   = (i_byte > {2'b00, i_cfg.max_pay}) || (len_total > 9'(BUF_SIZE));
        exp_len   = FW'(len_total);
        fill_inc  = r_fill + FW'(1);
        room      = r_fill < FW'(BUF_SIZE);
        pay_done  = (r_exp != '0) && (fill_inc >= r_exp);
    end

    // Next parse state
    always_comb begin
        n_st = r_st;
        if (i_clear) begin
            n_st = mlfr_pkg::PS_MAGIC;
        end else if (step) begin
            if (restart) begin
                n_st = mlfr_pkg::PS_TYPE;
            end else begin
                case (r_st)
                    mlfr_pkg::PS_TYPE: begin
                        n_st = type_ok ? mlfr_pkg::PS_SEQ : mlfr_pkg::PS_MAGIC;
                    end
                    mlfr_pkg::PS_SEQ: begin
                        n_st = mlfr_pkg::PS_LEN;
                    end
                    mlfr_pkg::PS_LEN: begin
                        n_st = (len_bad || (i_byte == 8'd0)) ? mlfr_pkg::PS_MAGIC
                                                              : mlfr_pkg::PS_PAYLOAD;
                    end
                    mlfr_pkg::PS_PAYLOAD: begin
                        n_st = (!room || pay_done) ? mlfr_pkg::PS_MAGIC
                                                   : mlfr_pkg::PS_PAYLOAD;
                    end
                    default: begin
                        n_st = r_st;
                    end
                endcase
            end
        end
    end

    // Buffer writes, fill, expected length, ready flag and counters
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_fill[AW-1:0];
        o_wr_data = i_byte;
        n_fill    = r_fill;
        n_exp     = r_exp;
        n_ready   = r_ready;
        n_bytes   = i_rx ? r_bytes + 32'd1 : r_bytes;
        n_frames  = r_frames;
        if (i_clear) begin
            n_ready = 1'b0;
            n_fill  = '0;
            n_exp   = '0;
        end else if (step) begin
            if (restart) begin
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                n_fill    = FW'(1);
            end else begin
                case (r_st)
                    mlfr_pkg::PS_TYPE: begin
                        o_wr_en = 1'b1;
                        if (type_ok) begin
                            n_fill = fill_inc;
                        end else begin
                            n_fill = '0;
                            n_exp  = '0;
                        end
                    end
                    mlfr_pkg::PS_SEQ: begin
                        o_wr_en = 1'b1;
                        n_fill  = fill_inc;
                    end
                    mlfr_pkg::PS_LEN: begin
                        o_wr_en = 1'b1;
                        if (len_bad) begin
                            n_fill = '0;
                            n_exp  = '0;
                        end else if (i_byte == 8'd0) begin
                            n_fill  = fill_inc;
                            n_ready = 1'b1;
                            n_exp   = '0;
                        end else begin
                            n_fill = fill_inc;
                            n_exp  = exp_len;
                        end
                    end
                    mlfr_pkg::PS_PAYLOAD: begin
                        if (room) begin
                            o_wr_en = 1'b1;
                            n_fill  = fill_inc;
                            if (pay_done) begin
                                n_ready  = 1'b1;
                                n_frames = r_frames + 32'd1;
                                n_exp    = '0;
                            end
                        end else begin
                            n_fill = '0;
                            n_exp  = '0;
                        end
                    end
                    default: begin
                        o_wr_en = 1'b0;
                    end
                endcase
            end
        end
    end

    // Advance parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= mlfr_pkg::PS_MAGIC;
            r_fill   <= '0;
            r_exp    <= '0;
            r_ready  <= 1'b0;
            r_bytes  <= '0;
            r_frames <= '0;
        end else begin
            r_st     <= n_st;
            r_fill   <= n_fill;
            r_exp    <= n_exp;
            r_ready  <= n_ready;
            r_bytes  <= n_bytes;
            r_frames <= n_frames;
        end
    end

    assign o_ready            = r_ready;
    assign o_fill             = r_fill;
    assign o_stat.ready       = n_ready;
    assign o_stat.rcv_bytes   = n_bytes;
    assign o_stat.done_frames = n_frames;

endmodule

// ----- hw/rtl/magic_length_frame_receiver.sv -----
// Top level: configuration, input handshake, readout sequencer and output register.
// Timing: a result is loaded into the output register at the accepting edge, except
// that a read of a waiting frame loads its first byte after a buffer read issued
// from the read state. Throughput: one receive item per cycle while o_in_stall is low;
// a read runs: acceptance, a buffer read, then one byte per cycle unless output stalls.
// Reset: parser state, counters, configuration and handshake clear; the buffer does not.
`timescale 1ns / 1ps

module magic_length_frame_receiver #(
    parameter int unsigned BUF_SIZE = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_op,
    input  logic [7:0]                       i_rx_byte,
    input  logic [7:0]                       i_max_len,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_data,
    output logic                             o_has_data,
    output logic                             o_last,
    output logic [6:0]                       o_count,
    output logic                             o_frame_ready,
    output logic [31:0]                      o_rcv_bytes,
    output logic [31:0]                      o_done_frames,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mlfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);

    localparam int unsigned FW = $clog2(BUF_SIZE + 1);
    localparam int unsigned AW = $clog2(BUF_SIZE);

    mlfr_pkg::t_cfg        r_cfg;
    mlfr_pkg::t_top_st     r_st, n_st;
    mlfr_pkg::t_parse_stat stat;

    logic          ready;
    logic [FW-1:0] fill;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    rd_data;

    logic [FW-1:0] r_n, r_issued, r_emit;
    logic          r_pend;
    logic [FW-1:0] n_len;

    logic          out_free;
    logic          accept;
    logic          rx;
    logic          clear;
    logic          start_read;
    logic          load_idle;
    logic          load_rd;
    logic          issue;
    logic          emit_last;

    logic          r_out_valid;
    logic [7:0]    r_data;
    logic          r_has_data;
    logic          r_last;
    logic [6:0]    r_count;
    logic          r_frame_ready;
    logic [31:0]   r_rcv_bytes;
    logic [31:0]   r_done_frames;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic   <= mlfr_pkg::MAGIC_RST;
            r_cfg.type_a  <= mlfr_pkg::TYPE_A_RST;
            r_cfg.type_b  <= mlfr_pkg::TYPE_B_RST;
            r_cfg.max_pay <= mlfr_pkg::MAX_PAY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mlfr_pkg::CFG_MAGIC:   r_cfg.magic   <= i_cfg_data;
                mlfr_pkg::CFG_TYPE_A:  r_cfg.type_a  <= i_cfg_data;
                mlfr_pkg::CFG_TYPE_B:  r_cfg.type_b  <= i_cfg_data;
                mlfr_pkg::CFG_MAX_PAY: r_cfg.max_pay <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // Bytes to read out: the smaller of fill and max_len
    assign n_len = ({1'b0, i_max_len} < 9'(fill)) ? FW'(i_max_len) : fill;

    // Handshake and sequencer controls
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        accept     = 1'b0;
        o_in_stall = 1'b1;
        issue      = 1'b0;
        load_rd    = 1'b0;
        case (r_st)
            mlfr_pkg::TS_IDLE: begin
                o_in_stall = !out_free;
                accept     = i_in_valid && out_free;
            end
            mlfr_pkg::TS_READ: begin
                load_rd = r_pend && out_free;
                issue   = (r_issued < r_n) && (!r_pend || load_rd);
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
        rx         = accept && (i_op == mlfr_pkg::OP_RECEIVE);
        clear      = accept && (i_op == mlfr_pkg::OP_READ) && ready;
        start_read = clear && (n_len != '0);
        load_idle  = accept && !start_read;
        emit_last  = (r_emit + FW'(1)) == r_n;
    end

    // Next sequencer state
    always_comb begin
        n_st = r_st;
        case (r_st)
            mlfr_pkg::TS_IDLE: begin
                if (start_read) begin
                    n_st = mlfr_pkg::TS_READ;
                end
            end
            mlfr_pkg::TS_READ: begin
                if (load_rd && emit_last) begin
                    n_st = mlfr_pkg::TS_IDLE;
                end
            end
            default: begin
                n_st = mlfr_pkg::TS_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= mlfr_pkg::TS_IDLE;
            r_pend   <= 1'b0;
            r_issued <= '0;
            r_emit   <= '0;
        end else begin
            r_st <= n_st;
            if (start_read) begin
                r_pend   <= 1'b0;
                r_issued <= '0;
                r_emit   <= '0;
            end else begin
                if (issue) begin
                    r_pend   <= 1'b1;
                    r_issued <= r_issued + FW'(1);
                end else if (load_rd) begin
                    r_pend <= 1'b0;
                end
                if (load_rd) begin
                    r_emit <= r_emit + FW'(1);
                end
            end
        end
    end

    // Hold the read length
    always_ff @(posedge i_clk) begin
        if (start_read) begin
            r_n <= n_len;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_idle || load_rd) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (load_idle || load_rd) begin
            r_data        <= load_rd ? rd_data : 8'd0;
            r_has_data    <= load_rd;
            r_last        <= load_rd ? emit_last : 1'b1;
            r_count       <= load_rd ? 7'(r_n) : 7'd0;
            r_frame_ready <= stat.ready;
            r_rcv_bytes   <= stat.rcv_bytes;
            r_done_frames <= stat.done_frames;
        end
    end

    mlfr_parse #(
        .BUF_SIZE (BUF_SIZE)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_rx      (rx),
        .i_byte    (i_rx_byte),
        .i_clear   (clear),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_ready   (ready),
        .o_fill    (fill),
        .o_stat    (stat)
    );

    mlfr_buf #(
        .BUF_SIZE (BUF_SIZE)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (r_issued[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_out_valid   = r_out_valid;
    assign o_data        = r_data;
    assign o_has_data    = r_has_data;
    assign o_last        = r_last;
    assign o_count       = r_count;
    assign o_frame_ready = r_frame_ready;
    assign o_rcv_bytes   = r_rcv_bytes;
    assign o_done_frames = r_done_frames;

endmodule
